// File: hw/rtl/separable_box_blur_assert.svh
// Assertion macros for the box blur block.
`ifndef SEPARABLE_BOX_BLUR_ASSERT_SVH
`define SEPARABLE_BOX_BLUR_ASSERT_SVH

// Implication checked on every edge outside reset.
`define SBB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define SBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/sbb_pkg.sv
// ----------------------------------------------------------------------------
// sbb_pkg
// Shared constants and types of the box blur block.
// ----------------------------------------------------------------------------
package sbb_pkg;

  localparam int unsigned DefMaxWidth  = 256;
  localparam int unsigned DefMaxHeight = 256;
  localparam int unsigned DefMaxRadius = 15;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegRadius = 2'd2;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdRead  = 1'b1;

  localparam logic [7:0] AlphaOpaque = 8'hFF;

  // Divider request and response.
  typedef struct packed {
    logic        start;
    logic [17:0] num;
    logic [6:0]  den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [17:0] quot;
  } div_rsp_t;

endpackage

// File: hw/rtl/sbb_divider.sv
// ----------------------------------------------------------------------------
// sbb_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbb_divider
  import sbb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [17:0] quot_q, quot_d;
  logic [6:0]  rem_q, rem_d;
  logic [6:0]  den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [7:0]  trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[17]};
    if (req_i.start) begin
      quot_d = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 5'd18;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = 7'(trial - {1'b0, den_q});
        quot_d = {quot_q[16:0], 1'b1};
      end else begin
        rem_d = trial[6:0];
        quot_d = {quot_q[16:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// File: hw/rtl/separable_box_blur.sv
// ----------------------------------------------------------------------------
// separable_box_blur
// Frame store with a clamp-to-edge separable box blur read out.
// ----------------------------------------------------------------------------
// An item with cmd low writes one RGB pixel into the frame store in the cycle
// it is accepted; busy stays low after it, so another item may follow at once.
// An item with cmd high returns one blurred pixel on pixel_out_o, marked by a
// one-cycle valid_o strobe that the receiver must take: it cannot stall.
// A read walks (2r+1) rows of (2r+1) taps, one memory read per cycle, and
// divides each row sum and the final sum by 2r+1 on a shared serial divider,
// one channel after another. busy stays high until the result is ready, and
// the result strobe is raised in the cycle that busy falls. The memory read
// port and the divider set the rate. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module separable_box_blur
  import sbb_pkg::*;
#(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned MaxHeight = DefMaxHeight,
  parameter int unsigned MaxRadius = DefMaxRadius
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [7:0]  pos_x_i,
  input  logic [7:0]  pos_y_i,
  input  logic [31:0] pixel_in_i,
  output logic        valid_o,
  output logic [31:0] pixel_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  `include "separable_box_blur_assert.svh"

  localparam int unsigned XW = (MaxWidth  > 1) ? $clog2(MaxWidth)  : 1;
  localparam int unsigned YW = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  localparam int unsigned Depth = 2 ** (XW + YW);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRow   = 7'b0000010,
    StTap   = 7'b0000100,
    StDrain = 7'b0001000,
    StHdiv  = 7'b0010000,
    StVdiv  = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [8:0] width_q, height_q;
  logic [3:0] radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      radius_q <= 4'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegWidth:  width_q  <= cfg_data_i;
        RegHeight: height_q <= cfg_data_i;
        RegRadius: radius_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // effective sizes, saturated
  logic [12:0] wmax, hmax;
  logic [6:0]  rad;
  logic [6:0]  taps;
  always_comb begin
    wmax = (width_q == 9'd0) ? 13'd0 :
           ({4'd0, width_q} > 13'(MaxWidth)) ? 13'(MaxWidth - 1) : 13'({4'd0, width_q} - 13'd1);
    hmax = (height_q == 9'd0) ? 13'd0 :
           ({4'd0, height_q} > 13'(MaxHeight)) ? 13'(MaxHeight - 1) :
           13'({4'd0, height_q} - 13'd1);
    rad  = ({3'd0, radius_q} > 7'(MaxRadius)) ? 7'(MaxRadius) : {3'd0, radius_q};
    taps = 7'({rad, 1'b0} + 7'd1);
  end

  // frame store
  logic [23:0] mem [Depth];
  logic [23:0] rd_data_q;
  logic        wr_en;
  logic [XW+YW-1:0] wr_addr, rd_addr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= pixel_in_i[23:0];
    end
    rd_data_q <= mem[rd_addr];
  end

  // read walk
  logic [12:0] cx_q, cy_q, cx_d, cy_d;
  logic signed [14:0] dx_q, dy_q, dx_d, dy_d;
  logic [12:0] row_q, row_d, col;
  logic        rd_pend_q, rd_pend_d;
  logic [17:0] hsum_q [3];
  logic [17:0] hsum_d [3];
  logic [17:0] vsum_q [3];
  logic [17:0] vsum_d [3];
  logic [7:0]  res_q [3];
  logic [7:0]  res_d [3];
  logic [1:0]  ch_q, ch_d;
  logic        valid_q, valid_d;
  div_req_t    dreq;
  div_rsp_t    drsp;

  function automatic logic [12:0] clampc(input logic signed [14:0] v, input logic [12:0] hi);
    logic [12:0] r;
    if (v < 0) r = '0;
    else if (v > $signed({2'b0, hi})) r = hi;
    else r = v[12:0];
    return r;
  endfunction

  assign col = clampc($signed({2'b0, cx_q}) + dx_q, wmax);
  assign rd_addr = {row_q[YW-1:0], col[XW-1:0]};
  assign busy = (state_q != StIdle);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = {YW'(pos_y_i), XW'(pos_x_i)};
    if (start && !busy && cmd_i == CmdWrite &&
        {5'd0, pos_x_i} < 13'(MaxWidth) && {5'd0, pos_y_i} < 13'(MaxHeight)) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    cx_d = cx_q; cy_d = cy_q; dx_d = dx_q; dy_d = dy_q; row_d = row_q;
    rd_pend_d = 1'b0;
    hsum_d = hsum_q; vsum_d = vsum_q; res_d = res_q; ch_d = ch_q;
    valid_d = 1'b0;
    dreq = '0;
    unique case (state_q)
      StIdle: begin
        if (start && cmd_i == CmdRead) begin
          cx_d = clampc({7'd0, pos_x_i}, wmax);
          cy_d = clampc({7'd0, pos_y_i}, hmax);
          dy_d = -$signed({8'd0, rad});
          for (int i = 0; i < 3; i++) vsum_d[i] = '0;
          state_d = StRow;
        end
      end
      StRow: begin
        // begin one row of the window
        row_d = clampc($signed({2'b0, cy_q}) + dy_q, hmax);
        dx_d  = -$signed({8'd0, rad});
        for (int i = 0; i < 3; i++) hsum_d[i] = '0;
        state_d = StTap;
      end
      StTap: begin
        rd_pend_d = 1'b1;
        if (rd_pend_q) begin
          hsum_d[0] = hsum_q[0] + {10'd0, rd_data_q[23:16]};
          hsum_d[1] = hsum_q[1] + {10'd0, rd_data_q[15:8]};
          hsum_d[2] = hsum_q[2] + {10'd0, rd_data_q[7:0]};
        end
        if (dx_q == $signed({8'd0, rad})) state_d = StDrain;
        else dx_d = dx_q + 15'sd1;
      end
      StDrain: begin
        hsum_d[0] = hsum_q[0] + {10'd0, rd_data_q[23:16]};
        hsum_d[1] = hsum_q[1] + {10'd0, rd_data_q[15:8]};
        hsum_d[2] = hsum_q[2] + {10'd0, rd_data_q[7:0]};
        ch_d = 2'd0;
        dreq.start = 1'b1; dreq.num = hsum_d[0]; dreq.den = taps;
        state_d = StHdiv;
      end
      StHdiv: begin
        if (drsp.done) begin
          vsum_d[ch_q] = vsum_q[ch_q] + drsp.quot;
          if (ch_q == 2'd2) begin
            if (dy_q == $signed({8'd0, rad})) begin
              ch_d = 2'd0;
              dreq.start = 1'b1; dreq.num = vsum_d[0]; dreq.den = taps;
              state_d = StVdiv;
            end else begin
              dy_d = dy_q + 15'sd1;
              state_d = StRow;
            end
          end else begin
            ch_d = ch_q + 2'd1;
            dreq.start = 1'b1; dreq.num = hsum_q[ch_q + 2'd1]; dreq.den = taps;
          end
        end
      end
      StVdiv: begin
        if (drsp.done) begin
          res_d[ch_q] = drsp.quot[7:0];
          if (ch_q == 2'd2) begin
            state_d = StOut;
          end else begin
            ch_d = ch_q + 2'd1;
            dreq.start = 1'b1; dreq.num = vsum_q[ch_q + 2'd1]; dreq.den = taps;
          end
        end
      end
      StOut: begin
        valid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  sbb_divider u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .rsp_o (drsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      rd_pend_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_pend_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d; cy_q <= cy_d; dx_q <= dx_d; dy_q <= dy_d; row_q <= row_d;
    hsum_q <= hsum_d; vsum_q <= vsum_d; res_q <= res_d; ch_q <= ch_d;
  end

  assign valid_o = valid_q;
  assign pixel_out_o = {AlphaOpaque, res_q[0], res_q[1], res_q[2]};

  `SBB_ASSERT_NEXT(a_out_after_last, clk_i, rst_ni, state_q == StOut, valid_o)
  `SBB_ASSERT_IMP(a_no_write_busy, clk_i, rst_ni, wr_en, state_q == StIdle)
  `SBB_ASSERT_IMP(a_valid_idle, clk_i, rst_ni, valid_o, state_q == StIdle)

endmodule
